// File: hdl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, register codes and the sieve hole table.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int COORD_BITS_DEF = 18;
  localparam int HOLE_COUNT     = 86;
  localparam int RADIUS_SQ_BITS = 32;

  localparam logic [RADIUS_SQ_BITS-1:0] SMALL_R2_RST = 32'd490000;
  localparam logic [RADIUS_SQ_BITS-1:0] LARGE_R2_RST = 32'd1809025;

  typedef enum logic [0:0] {
    REG_SMALL_R2 = 1'b0,
    REG_LARGE_R2 = 1'b1
  } sha_reg_e;

  // control that travels down the chain next to the point
  typedef struct packed {
    logic valid;
    logic in_hole;
  } sha_ctl_t;

  // hole centres in micrometres; the first three are the large holes
  localparam int HOLE_CX [HOLE_COUNT] = '{
    0, 26600, -19950,
    -26600, -13300, 13300, 26600, 39900,
    -26600, -13300, 0, 13300, 26600, 39900,
    -26600, -13300, 0, 13300, 26600, 39900,
    -26600, -13300, 0, 13300, 26600, 39900,
    -26600, -13300, 0, 13300, 26600, 39900,
    -26600, -13300, 0, 13300, 39900,
    -26600, -13300, 0, 13300, 26600, 39900,
    -26600, -13300, 0, 13300, 26600, 39900,
    -39910, -39910, -39910, -39910, -39910, -39910, -39910, -39910,
    6650, 6650, 6650, 6650, 6650,
    -6650, -6650, -6650, -6650, -6650,
    19950, 19950, 19950, 19950, 19950,
    33250, 33250, 33250, 33250, 33250,
    -19950, -19950, -19950, -19950,
    -33950, -33950, -33950, -33950, -33950
  };

  localparam int HOLE_CY [HOLE_COUNT] = '{
    0, -6120, 8520,
    0, 0, 0, 0, 0,
    6120, 6120, 6120, 6120, 6120, 6120,
    10920, 10920, 10920, 10920, 10920, 10920,
    15720, 15720, 15720, 15720, 15720, 15720,
    20520, 20520, 20520, 20520, 20520, 20520,
    -6120, -6120, -6120, -6120, -6120,
    -12240, -12240, -12240, -12240, -12240, -12240,
    -18360, -18360, -18360, -18360, -18360, -18360,
    0, 6120, 10920, 15720, 20520, -6120, -12240, -18360,
    -3060, -15300, -21420, 18120, 8520,
    -3060, -15300, -21420, 8520, 18120,
    -3060, -15300, -21420, 8520, 18120,
    -3060, -15300, -21420, 8520, 18120,
    -3060, -15300, -21420, 18120,
    -3060, -15300, -21420, 18120, 8520
  };

  localparam int LARGE_HOLES = 3;

endpackage

// File: hdl/sieve_hole_acceptance.sv
// ----------------------------------------------------------------------------
// sieve_hole_acceptance
// Tests hit points against the sieve hole pattern, one point per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one hit request, x_um_i
//   and y_um_i in signed micrometres. Output channel (out_valid_o /
//   out_ready_i) returns blocked_o: 1 when the negated point is in no hole.
//   The point walks down a row of 86 cells, one per hole, each two register
//   stages deep, on its way to out_valid_o, and a new request is taken every
//   cycle while the receiver does not stall. Throughput is set by the cell
//   row, which moves as a whole.
//   When the receiver stalls, the whole row holds and in_ready_o drops in
//   the same cycle; the last cell stage doubles as the output register.
//   Reset empties the row and loads the default squared radii.
//   Radius registers are written over cfg_we_i / cfg_idx_i / cfg_data_i; the user must
//   write them only while no request is in flight, as the block does not enforce it.
// ----------------------------------------------------------------------------
module sieve_hole_acceptance import sha_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [COORD_BITS-1:0]     x_um_i,
  input  logic [COORD_BITS-1:0]     y_um_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      blocked_o,
  input  logic                      cfg_we_i,
  input  sha_reg_e                  cfg_idx_i,
  input  logic [RADIUS_SQ_BITS-1:0] cfg_data_i
);

  logic [RADIUS_SQ_BITS-1:0] small_r2_q, large_r2_q;
  logic                      adv;

  sha_ctl_t                   ctl [HOLE_COUNT+1];
  logic signed [COORD_BITS:0] px  [HOLE_COUNT+1];
  logic signed [COORD_BITS:0] py  [HOLE_COUNT+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_r2_q <= SMALL_R2_RST;
      large_r2_q <= LARGE_R2_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SMALL_R2: small_r2_q <= cfg_data_i;
        REG_LARGE_R2: large_r2_q <= cfg_data_i;
        default:      small_r2_q <= small_r2_q;
      endcase
    end
  end

  assign adv        = !ctl[HOLE_COUNT].valid || out_ready_i;
  assign in_ready_o = adv;

  // negate with one extra bit so the most negative input does not wrap
  assign ctl[0].valid   = in_valid_i;
  assign ctl[0].in_hole = 1'b0;
  assign px[0] = $signed((COORD_BITS+1)'(0) - {x_um_i[COORD_BITS-1], x_um_i});
  assign py[0] = $signed((COORD_BITS+1)'(0) - {y_um_i[COORD_BITS-1], y_um_i});

  for (genvar k = 0; k < HOLE_COUNT; k++) begin : g_cell
    sha_cell #(
      .COORD_BITS (COORD_BITS),
      .CX         (HOLE_CX[k]),
      .CY         (HOLE_CY[k]),
      .BIG        (k < LARGE_HOLES)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .ctl_i      (ctl[k]),
      .px_i       (px[k]),
      .py_i       (py[k]),
      .small_r2_i (small_r2_q),
      .large_r2_i (large_r2_q),
      .ctl_o      (ctl[k+1]),
      .px_o       (px[k+1]),
      .py_o       (py[k+1])
    );
  end

  assign out_valid_o = ctl[HOLE_COUNT].valid;
  assign blocked_o   = !ctl[HOLE_COUNT].in_hole;

`ifndef SYNTH
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a stalled result");

  a_row_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(ctl[1]))
    else $error("first cell moved during a stall");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(blocked_o)))
    else $error("stalled result dropped or changed");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output stage");
`endif

endmodule

// File: hdl/sha_cell.sv
// ----------------------------------------------------------------------------
// sha_cell
// One hole of the sieve: two-stage test of the passing point, ORed into the
// in-hole flag that is handed on to the next cell.
// ----------------------------------------------------------------------------
module sha_cell import sha_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int CX         = 0,
  parameter int CY         = 0,
  parameter bit BIG        = 1'b0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  sha_ctl_t                  ctl_i,
  input  logic signed [COORD_BITS:0] px_i,
  input  logic signed [COORD_BITS:0] py_i,
  input  logic [RADIUS_SQ_BITS-1:0] small_r2_i,
  input  logic [RADIUS_SQ_BITS-1:0] large_r2_i,
  output sha_ctl_t                  ctl_o,
  output logic signed [COORD_BITS:0] px_o,
  output logic signed [COORD_BITS:0] py_o
);

  localparam int DW = COORD_BITS + 2;
  localparam logic signed [DW-1:0] CX_V = DW'(CX);
  localparam logic signed [DW-1:0] CY_V = DW'(CY);

  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        mag_x, mag_y;
  logic                 far_d;
  logic [31:0]          dxsq_d, dysq_d;

  sha_ctl_t                   ctl1_q, ctl2_q;
  logic signed [COORD_BITS:0] px1_q, py1_q, px2_q, py2_q;
  logic [31:0]                dxsq_q, dysq_q;
  logic                       far_q;

  logic [RADIUS_SQ_BITS-1:0] r2;
  logic [32:0]               dist_sq;
  logic                      hit;

  assign dx    = $signed({px_i[COORD_BITS], px_i}) - CX_V;
  assign dy    = $signed({py_i[COORD_BITS], py_i}) - CY_V;
  assign mag_x = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign mag_y = dy[DW-1] ? DW'(-dy) : DW'(dy);
  // 65536 or more on either axis is outside any 32-bit squared radius
  assign far_d  = (|mag_x[DW-1:16]) | (|mag_y[DW-1:16]);
  assign dxsq_d = mag_x[15:0] * mag_x[15:0];
  assign dysq_d = mag_y[15:0] * mag_y[15:0];

  assign r2      = BIG ? large_r2_i : small_r2_i;
  assign dist_sq = {1'b0, dxsq_q} + {1'b0, dysq_q};
  assign hit     = !far_q && (dist_sq < {1'b0, r2});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (adv_i) begin
      ctl1_q         <= ctl_i;
      ctl2_q.valid   <= ctl1_q.valid;
      ctl2_q.in_hole <= ctl1_q.in_hole | hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      px1_q  <= px_i;
      py1_q  <= py_i;
      dxsq_q <= dxsq_d;
      dysq_q <= dysq_d;
      far_q  <= far_d;
      px2_q  <= px1_q;
      py2_q  <= py1_q;
    end
  end

  assign ctl_o = ctl2_q;
  assign px_o  = px2_q;
  assign py_o  = py2_q;

endmodule
